@@ rtl/core/vrn_pkg.sv @@
package vrn_pkg;

	localparam int IntFrac = 30;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INC_ZERO = 2'd1,
		ST_NRM_ZERO = 2'd2
	} status_t;

	// Unit vector job travelling along the normalize pipeline.
	typedef struct packed {
		logic zero;
		logic neg_x;
		logic neg_y;
		logic [31:0] mx;
		logic [31:0] my;
	} vec_t;

	// Square root cell state: remainder and partial root.
	typedef struct packed {
		logic [63:0] num;
		logic [63:0] res;
	} sqrt_t;

	// Division cell state for one component.
	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] quo;
		logic [63:0] dvd;
	} div_t;

endpackage

@@ rtl/core/vrn_sqrt_cell.sv @@
module vrn_sqrt_cell
	import vrn_pkg::*;
#(
	parameter int Step = 0
) (
	input logic clk,
	input sqrt_t din,
	output sqrt_t dout
);

	localparam logic [63:0] Bit = 64'd1 << (62 - 2 * Step);

	sqrt_t nxt;

	always_comb begin
		nxt = din;
		if (din.num >= din.res + Bit) begin
			nxt.num = din.num - (din.res + Bit);
			nxt.res = (din.res >> 1) + Bit;
		end else begin
			nxt.res = din.res >> 1;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

@@ rtl/core/vrn_div_cell.sv @@
module vrn_div_cell
	import vrn_pkg::*;
(
	input logic clk,
	input logic [31:0] den,
	input div_t din,
	output div_t dout
);

	logic [64:0] trial;
	logic [63:0] sh;

	always_comb begin
		sh = {din.rem[62:0], din.dvd[63]};
		trial = {1'b0, sh} - {33'd0, den};
	end

	always_ff @(posedge clk) begin
		dout.dvd <= {din.dvd[62:0], 1'b0};
		if (!trial[64]) begin
			dout.rem <= trial[63:0];
			dout.quo <= {din.quo[30:0], 1'b1};
		end else begin
			dout.rem <= sh;
			dout.quo <= {din.quo[30:0], 1'b0};
		end
	end

endmodule

@@ rtl/core/vrn_unit.sv @@
module vrn_unit
	import vrn_pkg::*;
(
	input logic clk,
	input logic [31:0] raw_x,
	input logic [31:0] raw_y,
	output logic zero,
	output logic signed [32:0] ux,
	output logic signed [32:0] uy
);

	localparam int NSq = 32;
	localparam int NDv = 64;

	vec_t v_s1;
	logic [31:0] mx, my, m;
	logic [4:0] lz;
	logic [63:0] sq_s2;
	vec_t v_s2;

	always_comb begin
		mx = raw_x[31] ? (32'd0 - raw_x) : raw_x;
		my = raw_y[31] ? (32'd0 - raw_y) : raw_y;
		m = (mx > my) ? mx : my;
		lz = 5'd0;
		for (int i = 0; i <= 30; i++) begin
			if (m[i]) lz = 5'(30 - i);
		end
		if (m[31]) lz = 5'd0;
	end

	always_ff @(posedge clk) begin
		v_s1.zero <= (m == 32'd0);
		v_s1.neg_x <= raw_x[31];
		v_s1.neg_y <= raw_y[31];
		v_s1.mx <= mx << lz;
		v_s1.my <= my << lz;
	end

	always_ff @(posedge clk) begin
		sq_s2 <= 64'(v_s1.mx) * 64'(v_s1.mx) + 64'(v_s1.my) * 64'(v_s1.my);
		v_s2 <= v_s1;
	end

	sqrt_t sq [NSq + 1];
	vec_t vq [NSq + 1];
	assign sq[0] = '{num: sq_s2, res: 64'd0};
	assign vq[0] = v_s2;

	for (genvar g = 0; g < NSq; g++) begin : g_sq
		vrn_sqrt_cell #(.Step(g)) u_cell (.clk(clk), .din(sq[g]), .dout(sq[g + 1]));
		always_ff @(posedge clk) vq[g + 1] <= vq[g];
	end

	logic [31:0] len;
	assign len = sq[NSq].res[31:0];

	div_t dx [NDv + 1];
	div_t dy [NDv + 1];
	logic [31:0] lq [NDv + 1];
	vec_t wq [NDv + 1];
	assign lq[0] = len;
	assign wq[0] = vq[NSq];
	assign dx[0] = '{rem: 64'd0, quo: 32'd0,
		dvd: (64'(vq[NSq].mx) << IntFrac) + 64'(len >> 1)};
	assign dy[0] = '{rem: 64'd0, quo: 32'd0,
		dvd: (64'(vq[NSq].my) << IntFrac) + 64'(len >> 1)};

	for (genvar g = 0; g < NDv; g++) begin : g_dv
		vrn_div_cell u_dx (.clk(clk), .den(lq[g]), .din(dx[g]), .dout(dx[g + 1]));
		vrn_div_cell u_dy (.clk(clk), .den(lq[g]), .din(dy[g]), .dout(dy[g + 1]));
		always_ff @(posedge clk) begin
			lq[g + 1] <= lq[g];
			wq[g + 1] <= wq[g];
		end
	end

	logic signed [32:0] qx, qy;
	assign qx = $signed({1'b0, dx[NDv].quo});
	assign qy = $signed({1'b0, dy[NDv].quo});
	assign zero = wq[NDv].zero;
	assign ux = wq[NDv].neg_x ? -qx : qx;
	assign uy = wq[NDv].neg_y ? -qy : qy;

endmodule

@@ rtl/core/vector2_reflect_about_normal.sv @@
// Each accepted request runs through both normalize units and the reflect stages before done.
// Throughput: one request per cycle; busy is always low.
// Each normalize path is a row of 32 square root cells and, per component, 64 divide cells.
// Reset arst_n clears the valid chain only; data stages are not reset.
// The receiver cannot stall: each result is shown for one cycle with done.
module vector2_reflect_about_normal
	import vrn_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [31:0] incident_x,
	input logic signed [31:0] incident_y,
	input logic signed [31:0] normal_x,
	input logic signed [31:0] normal_y,
	output logic done,
	output logic signed [FRAC_BITS + 1:0] reflect_x,
	output logic signed [FRAC_BITS + 1:0] reflect_y,
	output logic [1:0] status
);

	localparam int UnitLat = 98;
	localparam int Lat = UnitLat + 6;
	localparam int Sh = IntFrac - FRAC_BITS;

	logic iz, nz;
	logic signed [32:0] ix, iy, nx, ny;

	vrn_unit u_inc (.clk(clk), .raw_x(incident_x), .raw_y(incident_y),
		.zero(iz), .ux(ix), .uy(iy));
	vrn_unit u_nrm (.clk(clk), .raw_x(normal_x), .raw_y(normal_y),
		.zero(nz), .ux(nx), .uy(ny));

	function automatic logic signed [63:0] rsh(input logic signed [65:0] v, input int k);
		logic [65:0] a;
		a = v[65] ? 66'(-v) : 66'(v);
		a = (a + (66'd1 << (k - 1))) >> k;
		return v[65] ? -64'(a) : 64'(a);
	endfunction

	logic signed [65:0] px_s1, py_s1;
	logic signed [32:0] ix_s1, iy_s1, nx_s1, ny_s1;
	logic [1:0] st_s1;
	logic signed [33:0] d_s2;
	logic signed [32:0] ix_s2, iy_s2, nx_s2, ny_s2;
	logic [1:0] st_s2;
	logic signed [65:0] tx_s3, ty_s3;
	logic signed [32:0] ix_s3, iy_s3;
	logic [1:0] st_s3;
	logic signed [35:0] rx_s4, ry_s4;
	logic [1:0] st_s4;
	logic signed [35:0] ox_s5, oy_s5;
	logic [1:0] st_s5;

	always_ff @(posedge clk) begin
		px_s1 <= 66'(ix) * 66'(nx);
		py_s1 <= 66'(iy) * 66'(ny);
		ix_s1 <= ix; iy_s1 <= iy; nx_s1 <= nx; ny_s1 <= ny;
		st_s1 <= iz ? ST_INC_ZERO : (nz ? ST_NRM_ZERO : ST_OK);
		d_s2 <= 34'(rsh(px_s1 + py_s1, IntFrac));
		ix_s2 <= ix_s1; iy_s2 <= iy_s1; nx_s2 <= nx_s1; ny_s2 <= ny_s1;
		st_s2 <= st_s1;
		tx_s3 <= 66'(d_s2) * 66'(nx_s2) * 66'sd2;
		ty_s3 <= 66'(d_s2) * 66'(ny_s2) * 66'sd2;
		ix_s3 <= ix_s2; iy_s3 <= iy_s2; st_s3 <= st_s2;
		rx_s4 <= 36'(ix_s3) - 36'(rsh(tx_s3, IntFrac));
		ry_s4 <= 36'(iy_s3) - 36'(rsh(ty_s3, IntFrac));
		st_s4 <= st_s3;
		ox_s5 <= 36'(rsh(66'(rx_s4), Sh));
		oy_s5 <= 36'(rsh(66'(ry_s4), Sh));
		st_s5 <= st_s4;
	end

	localparam logic signed [35:0] Lim = 36'sd1 <<< FRAC_BITS;

	function automatic logic signed [FRAC_BITS + 1:0] sat(input logic signed [35:0] v);
		logic signed [35:0] t;
		t = (v > Lim) ? Lim : ((v < -Lim) ? -Lim : v);
		return t[FRAC_BITS + 1:0];
	endfunction

	logic [Lat - 1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[Lat - 2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		reflect_x <= (st_s5 == ST_OK) ? sat(ox_s5) : '0;
		reflect_y <= (st_s5 == ST_OK) ? sat(oy_s5) : '0;
		status <= st_s5;
	end

	assign busy = 1'b0;
	assign done = vld_q[Lat - 1];

`ifndef SYNTH
	a_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy high");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> reflect_x == '0 && reflect_y == '0)
		else $error("nonzero result on error status");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> ##(Lat - 1) done) else $error("lost request");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == ST_OK || status == ST_INC_ZERO || status == ST_NRM_ZERO)
		else $error("bad status");
`endif

endmodule

@@ bench/vrn_checker.sv @@
module vrn_checker
	import vrn_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic signed [31:0] incident_x,
	input logic signed [31:0] incident_y,
	input logic signed [31:0] normal_x,
	input logic signed [31:0] normal_y,
	input logic done,
	input logic signed [17:0] reflect_x,
	input logic signed [17:0] reflect_y,
	input logic [1:0] status,
	output int errors,
	output int pending,
	output int seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FracBits = 16;

	typedef struct {
		logic signed [17:0] rx;
		logic signed [17:0] ry;
		status_t st;
	} reflection_t;

	reflection_t reflections_due[$];

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned acc;
		longint unsigned b;
		acc = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= acc + b) begin
				v = v - (acc + b);
				acc = (acc >> 1) + b;
			end else begin
				acc = acc >> 1;
			end
			b = b >> 2;
		end
		return acc;
	endfunction

	function automatic longint round_away(longint v, int k);
		longint unsigned half;
		half = 64'd1 << (k - 1);
		if (v < 0) return -longint'((unsigned'(-v) + half) >> k);
		return longint'((unsigned'(v) + half) >> k);
	endfunction

	function automatic bit to_unit(logic [31:0] ax, logic [31:0] ay,
			output longint ux, output longint uy);
		longint unsigned mx, my, m, len, qx, qy;
		mx = ax[31] ? (64'd1 << 32) - ax : ax;
		my = ay[31] ? (64'd1 << 32) - ay : ay;
		m = mx > my ? mx : my;
		ux = 0;
		uy = 0;
		if (m == 0) return 0;
		while (m < (64'd1 << 30)) begin
			m = m << 1;
			mx = mx << 1;
			my = my << 1;
		end
		len = root_floor(mx * mx + my * my);
		qx = ((mx << IntFrac) + (len >> 1)) / len;
		qy = ((my << IntFrac) + (len >> 1)) / len;
		ux = ax[31] ? -longint'(qx) : longint'(qx);
		uy = ay[31] ? -longint'(qy) : longint'(qy);
		return 1;
	endfunction

	function automatic logic signed [17:0] to_q1(longint r30);
		longint v;
		longint lim;
		lim = 64'sd1 << FracBits;
		v = round_away(r30, IntFrac - FracBits);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v[17:0];
	endfunction

	function automatic reflection_t reflect_about(logic [31:0] ix, logic [31:0] iy,
			logic [31:0] nx, logic [31:0] ny);
		reflection_t r;
		longint uix, uiy, unx, uny, d;
		r.rx = '0;
		r.ry = '0;
		if (!to_unit(ix, iy, uix, uiy)) begin
			r.st = ST_INC_ZERO;
			return r;
		end
		if (!to_unit(nx, ny, unx, uny)) begin
			r.st = ST_NRM_ZERO;
			return r;
		end
		d = round_away(uix * unx + uiy * uny, IntFrac);
		r.rx = to_q1(uix - round_away(2 * d * unx, IntFrac));
		r.ry = to_q1(uiy - round_away(2 * d * uny, IntFrac));
		r.st = ST_OK;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		reflection_t want;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
			seen <= 0;
		end else begin
			if (start && !busy)
				reflections_due.push_back(reflect_about(incident_x, incident_y,
					normal_x, normal_y));
			if (done) begin
				seen <= seen + 1;
				if (reflections_due.size() == 0) begin
					$error("result with no request pending");
					errors <= errors + 1;
				end else begin
					want = reflections_due.pop_front();
					if (reflect_x !== want.rx || reflect_y !== want.ry
							|| status !== want.st) begin
						if (reflect_x !== want.rx)
							$error("reflect_x expected %0d got %0d", want.rx, reflect_x);
						if (reflect_y !== want.ry)
							$error("reflect_y expected %0d got %0d", want.ry, reflect_y);
						if (status !== want.st)
							$error("status expected %0d got %0d", want.st, status);
						errors <= errors + 1;
					end
				end
			end
			pending <= reflections_due.size();
		end
	end

endmodule

@@ bench/tb.sv @@
module tb
	import vrn_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchLimit = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [31:0] incident_x = 0;
	logic signed [31:0] incident_y = 0;
	logic signed [31:0] normal_x = 0;
	logic signed [31:0] normal_y = 0;
	logic done;
	logic signed [17:0] reflect_x;
	logic signed [17:0] reflect_y;
	logic [1:0] status;
	int errors, pending, seen;
	int idle_pct;
	int sent;
	int quiet = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	vector2_reflect_about_normal u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.incident_x(incident_x), .incident_y(incident_y),
		.normal_x(normal_x), .normal_y(normal_y),
		.done(done), .reflect_x(reflect_x), .reflect_y(reflect_y), .status(status)
	);

	vrn_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.incident_x(incident_x), .incident_y(incident_y),
		.normal_x(normal_x), .normal_y(normal_y),
		.done(done), .reflect_x(reflect_x), .reflect_y(reflect_y), .status(status),
		.errors(errors), .pending(pending), .seen(seen)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WatchLimit) begin
			$display("vector2_reflect_about_normal regression: fail");
			$finish;
		end
	end

	task automatic send(logic [31:0] ix, logic [31:0] iy, logic [31:0] nx, logic [31:0] ny);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		incident_x <= ix;
		incident_y <= iy;
		normal_x <= nx;
		normal_y <= ny;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	function automatic logic [31:0] pick_comp();
		case ($urandom_range(9))
			0: return 0;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return $urandom_range(3) - 2;
			4, 5: return $signed($urandom_range(1 << 20)) - (1 << 19);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_request();
		logic [31:0] ix, iy, nx, ny;
		ix = pick_comp();
		iy = pick_comp();
		nx = pick_comp();
		ny = pick_comp();
		if ($urandom_range(19) == 0) begin
			ix = 0;
			iy = 0;
		end
		if ($urandom_range(19) == 0) begin
			nx = 0;
			ny = 0;
		end
		if ($urandom_range(9) == 0) begin
			nx = ix;
			ny = iy;
		end
		send(ix, iy, nx, ny);
	endtask

	initial begin
		sent = 0;
		idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(0, 0, 0, 0);
		send(0, 0, 32'h0001_0000, 0);
		send(32'h0001_0000, 0, 0, 0);
		send(32'h0001_0000, 32'hffff_0000, 0, 32'h0001_0000);
		send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send(1, 0, 0, 1);
		send(1, 1, 32'hffff_ffff, 1);
		send(32'h8000_0000, 1, 1, 32'h8000_0000);
		send(32'h0003_0000, 32'h0004_0000, 0, 32'h0000_0001);
		send(32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
		send(32'hffff_ffff, 0, 1, 0);
		send(32'h0000_b505, 32'h0000_b505, 32'h0001_0000, 32'h0001_0000);
		send(32'h1234_5678, 32'hedcb_a988, 32'h0000_0003, 32'hffff_fffb);
		send(0, 32'h8000_0000, 0, 0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: idle_pct = 0;
				1: idle_pct = 82;
				2: idle_pct = 13;
				default: idle_pct = 0;
			endcase
			repeat (450) random_request();
		end
		start <= 0;

		while (pending != 0 || sent != seen) @(posedge clk);
		repeat (120) @(posedge clk);
		$display("covered %0d requests: zero-length, extreme, axis and random vectors", sent);
		$display("sender gaps of 0, 13 and 82 percent; %0d results checked", seen);
		if (errors == 0 && sent == seen)
			$display("vector2_reflect_about_normal regression: pass");
		else
			$display("vector2_reflect_about_normal regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/vrn_pkg.sv
rtl/core/vrn_sqrt_cell.sv
rtl/core/vrn_div_cell.sv
rtl/core/vrn_unit.sv
rtl/core/vector2_reflect_about_normal.sv
bench/vrn_checker.sv
bench/tb.sv
